FILE: hdl/cfws_pkg.sv
// shared types and constants for the circular fifo with search
`timescale 1ns / 1ps

package cfws_pkg;

    localparam int DATA_W        = 32;
    localparam int REQ_W         = 2;
    localparam int STS_W         = 3;
    localparam int CAP_W         = 5;
    localparam int MAX_DEPTH_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [REQ_W-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_FIND = 2'd2,
        OP_DISP = 2'd3
    } t_op;

    typedef enum logic [STS_W-1:0] {
        STS_ENQUEUED   = 3'd0,
        STS_OVERFLOW   = 3'd1,
        STS_DEQUEUED   = 3'd2,
        STS_UNDERFLOW  = 3'd3,
        STS_FOUND      = 3'd4,
        STS_NOT_FOUND  = 3'd5,
        STS_DISP_ENTRY = 3'd6,
        STS_DISP_EMPTY = 3'd7
    } t_status;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [STS_W-1:0]         status;
        logic signed [DATA_W-1:0] data_out;
        logic                     last;
    } t_out_word;

    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

endpackage

FILE: hdl/cfws_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module cfws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/cfws_front.sv
// request intake: decodes request words into commands and queues them
`timescale 1ns / 1ps

module cfws_front
    import cfws_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_word i_word,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_pop
);

    localparam int QD   = 2;
    localparam int QI_W = $clog2(QD);

    t_cmd            r_q [QD];
    logic [QI_W-1:0] r_wp, r_rp;
    logic [QI_W:0]   r_cnt;
    logic            w_push, w_pop;
    t_cmd            w_cmd;

    assign o_stall     = (r_cnt == (QI_W+1)'(QD));
    assign o_cmd_valid = (r_cnt != '0);
    assign w_push      = i_valid && !o_stall;
    assign w_pop       = i_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        w_cmd.op    = t_op'(i_word.req_type);
        w_cmd.value = i_word.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

FILE: hdl/cfws_back.sv
// command executor: ring pointers, slot ram access, scans and result register
`timescale 1ns / 1ps

module cfws_back
    import cfws_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cmd_valid,
    input  t_cmd                               i_cmd,
    output logic                               o_pop,
    input  logic                               i_cfg_we,
    input  logic [CAP_W-1:0]                   i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output t_out_word                          o_out_word,
    output logic [$clog2(MAX_DEPTH+1)-1:0]     o_fill
);

    localparam int PTR_W = $clog2(MAX_DEPTH);
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEQ  = 4'b0010,
        S_FIND = 4'b0100,
        S_DISP = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [CAP_W-1:0]         r_cap, n_cap;
    logic [PTR_W-1:0]         r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]         r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]         r_scan_ptr, n_scan_ptr;
    logic [CNT_W-1:0]         r_fill, n_fill;
    logic [CNT_W-1:0]         r_left, n_left;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic                     r_out_valid, n_out_valid;
    t_out_word                r_out, n_out;

    logic [CNT_W-1:0]         w_cap;
    logic                     w_out_free;
    logic                     w_load;
    logic                     w_ram_we;
    logic                     w_ram_re;
    logic [PTR_W-1:0]         w_ram_raddr;
    logic [DATA_W-1:0]        w_ram_rdata;

    function automatic logic [PTR_W-1:0] adv(
        input logic [PTR_W-1:0] p,
        input logic [CNT_W-1:0] cap
    );
        logic [CNT_W:0] nxt;
        nxt = (CNT_W+1)'(p) + 1'b1;
        if (nxt >= (CNT_W+1)'(cap)) begin
            return '0;
        end
        return PTR_W'(nxt);
    endfunction

    cfws_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_cmd.value),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // effective capacity, clamped to 1..MAX_DEPTH
    always_comb begin
        if (r_cap == '0) begin
            w_cap = CNT_W'(1);
        end else if (32'(r_cap) > MAX_DEPTH) begin
            w_cap = CNT_W'(MAX_DEPTH);
        end else begin
            w_cap = CNT_W'(r_cap);
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_scan_ptr  = r_scan_ptr;
        n_fill      = r_fill;
        n_left      = r_left;
        n_key       = r_key;
        n_out       = r_out;
        w_load      = 1'b0;
        o_pop       = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        w_ram_raddr = r_scan_ptr;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_pop = 1'b1;
                    n_key = i_cmd.value;
                    case (i_cmd.op)
                        OP_ENQ: begin
                            w_load = 1'b1;
                            n_out.last = 1'b1;
                            if (r_fill >= w_cap) begin
                                n_out.status   = STS_OVERFLOW;
                                n_out.data_out = '0;
                            end else begin
                                w_ram_we       = 1'b1;
                                n_wr_ptr       = adv(r_wr_ptr, w_cap);
                                n_fill         = r_fill + 1'b1;
                                n_out.status   = STS_ENQUEUED;
                                n_out.data_out = i_cmd.value;
                            end
                        end
                        OP_DEQ: begin
                            if (r_fill == '0) begin
                                w_load         = 1'b1;
                                n_out.status   = STS_UNDERFLOW;
                                n_out.data_out = '0;
                                n_out.last     = 1'b1;
                            end else begin
                                w_ram_re    = 1'b1;
                                w_ram_raddr = r_rd_ptr;
                                n_state     = S_DEQ;
                            end
                        end
                        OP_FIND: begin
                            if (r_fill == '0) begin
                                w_load         = 1'b1;
                                n_out.status   = STS_NOT_FOUND;
                                n_out.data_out = i_cmd.value;
                                n_out.last     = 1'b1;
                            end else begin
                                w_ram_re    = 1'b1;
                                w_ram_raddr = r_rd_ptr;
                                n_scan_ptr  = adv(r_rd_ptr, w_cap);
                                n_left      = r_fill;
                                n_state     = S_FIND;
                            end
                        end
                        default: begin
                            if (r_fill == '0) begin
                                w_load         = 1'b1;
                                n_out.status   = STS_DISP_EMPTY;
                                n_out.data_out = '0;
                                n_out.last     = 1'b1;
                            end else begin
                                w_ram_re    = 1'b1;
                                w_ram_raddr = r_rd_ptr;
                                n_scan_ptr  = adv(r_rd_ptr, w_cap);
                                n_left      = r_fill;
                                n_state     = S_DISP;
                            end
                        end
                    endcase
                end
            end
            S_DEQ: begin
                if (w_out_free) begin
                    w_load         = 1'b1;
                    n_out.status   = STS_DEQUEUED;
                    n_out.data_out = w_ram_rdata;
                    n_out.last     = 1'b1;
                    n_rd_ptr       = adv(r_rd_ptr, w_cap);
                    n_fill         = r_fill - 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_FIND: begin
                if (w_ram_rdata == r_key || r_left == CNT_W'(1)) begin
                    if (w_out_free) begin
                        w_load         = 1'b1;
                        n_out.status   = (w_ram_rdata == r_key) ? STS_FOUND : STS_NOT_FOUND;
                        n_out.data_out = r_key;
                        n_out.last     = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    w_ram_re   = 1'b1;
                    n_scan_ptr = adv(r_scan_ptr, w_cap);
                    n_left     = r_left - 1'b1;
                end
            end
            S_DISP: begin
                if (w_out_free) begin
                    w_load         = 1'b1;
                    n_out.status   = STS_DISP_ENTRY;
                    n_out.data_out = w_ram_rdata;
                    n_out.last     = (r_left == CNT_W'(1));
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        w_ram_re   = 1'b1;
                        n_scan_ptr = adv(r_scan_ptr, w_cap);
                        n_left     = r_left - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // capacity write empties the ring
        if (i_cfg_we) begin
            n_cap    = i_cfg_data;
            n_rd_ptr = '0;
            n_wr_ptr = '0;
            n_fill   = '0;
        end

        n_out_valid = w_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_ptr <= n_scan_ptr;
        r_left     <= n_left;
        r_key      <= n_key;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_fill      = r_fill;

endmodule

FILE: hdl/circular_fifo_with_search.sv
// top level of the circular fifo with search
//
//   channel   direction   handshake               word
//   in        input       i_in_valid / o_in_stall  t_in_word  (req_type, value)
//   out       output      o_out_valid / i_out_stall t_out_word (status, data_out, last)
//   cfg       input       i_cfg_we                i_cfg_data (capacity_in_use)
//
// enqueue, and dequeue, find or display on an empty ring, load the result straight from idle
// dequeue reads the slot ram, then loads the result
// find reads up to n and display all n held entries, one read per cycle; display waits while output stalls
// synchronous reset empties the ring and sets capacity to 16; slot contents undefined
// a 2-word command queue lets intake run on while the executor or output stalls
`timescale 1ns / 1ps

module circular_fifo_with_search
    import cfws_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_DEPTH + 1);

    logic             w_cmd_valid;
    t_cmd             w_cmd;
    logic             w_pop;
    logic [CNT_W-1:0] w_fill;

    cfws_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_word      (i_in_word),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_pop       (w_pop)
    );

    cfws_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .o_fill      (w_fill)
    );

    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_cmd_valid)
        else $error("command taken from empty queue");

    a_cfg_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (w_fill == '0))
        else $error("ring not emptied by capacity write");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill <= CNT_W'(MAX_DEPTH))
        else $error("fill count beyond depth");

    a_pop_result_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (!o_out_valid || !i_out_stall))
        else $error("command started while result register blocked");

endmodule

FILE: test/circular_fifo_with_search_chk.sv
// checker for the circular fifo with search: ring predictor and result comparison
`timescale 1ns / 1ps

module circular_fifo_with_search_chk
    import cfws_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in_word         i_in_word,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out_word        i_out_word,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int DEPTH = MAX_DEPTH_DEF;
    localparam int PTR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] ring_slots [DEPTH];
    logic [PTR_W-1:0]  head_ptr;
    logic [PTR_W-1:0]  tail_ptr;
    logic [CAP_W-1:0]  held;
    logic [CAP_W-1:0]  capacity_reg;
    t_out_word         due_words [$];
    int                mismatches;

    function automatic int unsigned ring_size();
        int unsigned c;
        c = capacity_reg;
        if (c < 1) begin
            c = 1;
        end
        if (c > DEPTH) begin
            c = DEPTH;
        end
        return c;
    endfunction

    function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] p);
        int unsigned n;
        n = p + 1;
        return (n >= ring_size()) ? '0 : PTR_W'(n);
    endfunction

    task automatic owe(t_status s, logic [DATA_W-1:0] d, logic l);
        t_out_word w;
        w.status   = s;
        w.data_out = d;
        w.last     = l;
        due_words.push_back(w);
    endtask

    task automatic apply_request(t_in_word w);
        logic [PTR_W-1:0] p;
        int unsigned      i;
        logic             hit;
        case (t_op'(w.req_type))
            OP_ENQ: begin
                if (held >= ring_size()) begin
                    owe(STS_OVERFLOW, '0, 1'b1);
                end else begin
                    ring_slots[tail_ptr] = w.value;
                    tail_ptr = next_slot(tail_ptr);
                    held++;
                    owe(STS_ENQUEUED, w.value, 1'b1);
                end
            end
            OP_DEQ: begin
                if (held == 0) begin
                    owe(STS_UNDERFLOW, '0, 1'b1);
                end else begin
                    owe(STS_DEQUEUED, ring_slots[head_ptr], 1'b1);
                    head_ptr = next_slot(head_ptr);
                    held--;
                end
            end
            OP_FIND: begin
                hit = 1'b0;
                p   = head_ptr;
                for (i = 0; i < held && !hit; i++) begin
                    if (ring_slots[p] == w.value) begin
                        hit = 1'b1;
                    end else begin
                        p = next_slot(p);
                    end
                end
                owe(hit ? STS_FOUND : STS_NOT_FOUND, w.value, 1'b1);
            end
            default: begin
                if (held == 0) begin
                    owe(STS_DISP_EMPTY, '0, 1'b1);
                end else begin
                    p = head_ptr;
                    for (i = 0; i < held; i++) begin
                        owe(STS_DISP_ENTRY, ring_slots[p], (i + 1 == held));
                        p = next_slot(p);
                    end
                end
            end
        endcase
    endtask

    task automatic check_word(t_out_word got);
        t_out_word want;
        if (due_words.size() == 0) begin
            $error("unexpected word: status %0d data_out %0d last %0d",
                   got.status, got.data_out, got.last);
            mismatches++;
        end else begin
            want = due_words.pop_front();
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.data_out !== want.data_out) begin
                $error("data_out expected %0d actual %0d", want.data_out, got.data_out);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last expected %0d actual %0d", want.last, got.last);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_ptr     = '0;
            tail_ptr     = '0;
            held         = '0;
            capacity_reg = CAP_RESET;
            due_words.delete();
        end else begin
            if (i_cfg_we) begin
                capacity_reg = i_cfg_data;
                head_ptr     = '0;
                tail_ptr     = '0;
                held         = '0;
            end
            if (i_in_valid && !i_in_stall) begin
                apply_request(i_in_word);
            end
            if (i_out_valid && !i_out_stall) begin
                check_word(i_out_word);
            end
        end
        o_pending    <= due_words.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: test/circular_fifo_with_search_tb.sv
// testbench top for the circular fifo with search: stimulus, flow control and verdict
`timescale 1ns / 1ps

module circular_fifo_with_search_tb;
    import cfws_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_word         i_in_word;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_word        o_out_word;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_data;

    int                fail_count;
    int                pending;
    int                cycle_count = 0;
    int                hold_token  = 0;
    logic              rcv_idle    = 1'b1;
    logic              snd_idle;
    logic [DATA_W-1:0] recent_values [$];

    always #4 i_clk = ~i_clk;

    circular_fifo_with_search u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    circular_fifo_with_search_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("circular_fifo_with_search_tb failed");
            $finish;
        end
    end

    // output side: per-word random stall plus a long hold when the stimulus asks for one
    initial begin
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left  = 0;
        hold_left   = 0;
        hold_seen   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                stall_left = rcv_idle ? $urandom_range(0, 10) : 0;
            end
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(t_op op, logic [DATA_W-1:0] v);
        t_in_word w;
        int       gap;
        w.req_type = op;
        w.value    = v;
        gap = snd_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        if (op == OP_ENQ) begin
            recent_values.push_back(v);
            if (recent_values.size() > 8) begin
                void'(recent_values.pop_front());
            end
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] c);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return DATA_W'($urandom_range(0, 15));
            3:       return -DATA_W'($urandom_range(1, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_key();
        if (recent_values.size() > 0 && $urandom_range(0, 2) != 0) begin
            return recent_values[$urandom_range(0, recent_values.size() - 1)];
        end
        return pick_value();
    endfunction

    task automatic send_random(logic fill_bias);
        int  r;
        t_op op;
        r = $urandom_range(0, 9);
        if (fill_bias) begin
            op = (r < 5) ? OP_ENQ : (r < 7) ? OP_DEQ : (r < 9) ? OP_FIND : OP_DISP;
        end else begin
            op = (r < 2) ? OP_ENQ : (r < 6) ? OP_DEQ : (r < 8) ? OP_FIND : OP_DISP;
        end
        send_word(op, (op == OP_FIND) ? pick_key() : pick_value());
    endtask

    initial begin
        logic [CAP_W-1:0] phase_caps [9];
        logic             fill_bias;
        int               i;
        int               j;
        phase_caps = '{5'd31, 5'd2, 5'd1, 5'd17, 5'd3, 5'd0, 5'd8, 5'd16, 5'd4};
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        snd_idle   = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty ring at reset capacity, then enqueue, search, display and dequeue
        send_word(OP_DISP, 32'd0);
        send_word(OP_DEQ, 32'd0);
        send_word(OP_FIND, 32'd0);
        send_word(OP_ENQ, 32'h7fff_ffff);
        send_word(OP_ENQ, 32'h8000_0000);
        send_word(OP_ENQ, 32'h0000_0000);
        send_word(OP_ENQ, 32'hffff_ffff);
        send_word(OP_FIND, 32'h8000_0000);
        send_word(OP_FIND, 32'd5);
        send_word(OP_DISP, 32'd0);
        send_word(OP_DEQ, 32'd0);
        send_word(OP_DEQ, 32'd0);

        // capacity zero acts as a single slot
        set_capacity(5'd0);
        send_word(OP_ENQ, 32'd7);
        send_word(OP_ENQ, 32'd8);
        send_word(OP_DISP, 32'd0);
        send_word(OP_FIND, 32'd7);
        send_word(OP_DEQ, 32'd0);
        send_word(OP_DEQ, 32'd0);

        // output held off while enqueues past full are offered
        set_capacity(5'd16);
        snd_idle = 1'b0;
        hold_token <= hold_token + 1;
        for (i = 0; i < 20; i++) begin
            send_word(OP_ENQ, pick_value());
        end
        send_word(OP_DISP, 32'd0);
        send_word(OP_FIND, pick_key());
        for (i = 0; i < 4; i++) begin
            send_word(OP_DEQ, 32'd0);
        end

        for (i = 0; i < 9; i++) begin
            set_capacity((i >= 7) ? CAP_W'($urandom_range(0, 31)) : phase_caps[i]);
            snd_idle = ($urandom_range(0, 3) != 0);
            rcv_idle <= ($urandom_range(0, 3) != 0);
            fill_bias = 1'b1;
            for (j = 0; j < 40; j++) begin
                if ($urandom_range(0, 11) == 0) begin
                    fill_bias = !fill_bias;
                end
                send_random(fill_bias);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("circular_fifo_with_search_tb passed");
        end else begin
            $display("circular_fifo_with_search_tb failed");
        end
        $finish;
    end

endmodule
